FILE: src/pairwise_gravity_force_assert.svh
// Assertion macros used by the checker file.
`ifndef PAIRWISE_GRAVITY_FORCE_ASSERT_SVH
`define PAIRWISE_GRAVITY_FORCE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define PGF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pairwise_gravity_force: assertion failed");

// Next-cycle implication, off during reset.
`define PGF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pairwise_gravity_force: assertion failed");

// Next-cycle implication that also covers reset itself.
`define PGF_ASSERT_RESET(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pairwise_gravity_force: reset assertion failed");

`endif

FILE: src/pgf_pkg.sv
// ----------------------------------------------------------------------------
// pgf_pkg
// Widths, constants and the queue word type of the pair force pipeline.
// ----------------------------------------------------------------------------
package pgf_pkg;

  localparam int Axes      = 3;
  localparam int CoordW    = 32;
  localparam int MassW     = 32;
  localparam int ScaleW    = 32;
  localparam int ForceW    = 48;
  localparam int MagW      = 33;
  localparam int SqW       = 66;
  localparam int SumW      = 66;
  localparam int GmW       = 64;
  localparam int ChunkW    = 32;
  localparam int ProdW     = 96;
  localparam int Chunks    = ProdW / ChunkW;
  localparam int PrW       = ChunkW + MagW;
  localparam int PmW       = 128;
  localparam int RootW     = 49;
  localparam int RadW      = 99;
  localparam int RadShift  = 32;
  localparam int SqrtSteps = 49;
  localparam int SumLoW    = 33;
  localparam int RootLoW   = 25;
  localparam int PpW       = 58;
  localparam int DenW      = 115;
  localparam int QuoW      = 48;
  localparam int DivSteps  = QuoW;
  localparam int LowW      = 24;
  localparam int QDepth    = 2;

  localparam logic [ScaleW-1:0] ScaleReset = 32'h0001_0000;
  localparam logic signed [ForceW-1:0] ForceMax = {1'b0, {(ForceW-1){1'b1}}};
  localparam logic signed [ForceW-1:0] ForceMin = {1'b1, {(ForceW-1){1'b0}}};

  // One classified pair: squared distance, scaled mass products, signs.
  typedef struct packed {
    logic                        zero;
    logic [Axes-1:0]             pos;
    logic [SumW-1:0]             sum;
    logic [Axes-1:0][PmW-1:0]    pm;
  } pair_t;

endpackage

FILE: src/pairwise_gravity_force.sv
// ----------------------------------------------------------------------------
// pairwise_gravity_force
// Newtonian force on the first of two bodies, one pair per cycle unless stalled.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_stall) carries two positions and two masses;
// response channel (rsp_valid/rsp_stall) returns the Q24.24 force on the first
// body with a coincident-position flag and a clamp flag. G resets to 1.0 and is
// written via cfg_write/cfg_data; the user must write it only while the block is
// idle; the block does not enforce this. Throughput: one pair per cycle unless
// stalled. The path runs through six front stages, the queue, the 49-step root
// pipeline, the denominator product stages and the 48-step quotient pipeline.
// A two-word queue separates the front from the back. While rsp_stall holds
// a response, the back pipeline freezes; the front keeps accepting until the
// queue fills, then raises req_stall.
// Reset (rst, synchronous) empties every stage and the queue and sets G to 1.0.
// ----------------------------------------------------------------------------
module pairwise_gravity_force (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [pgf_pkg::ScaleW-1:0]          cfg_data,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic signed [pgf_pkg::CoordW-1:0]   first_x,
  input  logic signed [pgf_pkg::CoordW-1:0]   first_y,
  input  logic signed [pgf_pkg::CoordW-1:0]   first_z,
  input  logic signed [pgf_pkg::CoordW-1:0]   second_x,
  input  logic signed [pgf_pkg::CoordW-1:0]   second_y,
  input  logic signed [pgf_pkg::CoordW-1:0]   second_z,
  input  logic [pgf_pkg::MassW-1:0]           first_mass,
  input  logic [pgf_pkg::MassW-1:0]           second_mass,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic signed [pgf_pkg::ForceW-1:0]   force_x,
  output logic signed [pgf_pkg::ForceW-1:0]   force_y,
  output logic signed [pgf_pkg::ForceW-1:0]   force_z,
  output logic                                zero_distance,
  output logic                                saturated
);

  logic [pgf_pkg::ScaleW-1:0]  gravity_scale;
  logic                        front_en;
  logic                        back_en;
  logic                        front_valid;
  pgf_pkg::pair_t              front_pair;
  pgf_pkg::pair_t              head_pair;
  logic                        q_full;
  logic                        q_empty;
  logic                        q_push;
  logic                        q_pop;
  logic                        root_valid;
  pgf_pkg::pair_t              root_pair;
  logic [pgf_pkg::RootW-1:0]   root;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_scale <= pgf_pkg::ScaleReset;
    end else if (cfg_write) begin
      gravity_scale <= cfg_data;
    end
  end

  // back advances unless a held response blocks the output register
  assign back_en   = !rsp_valid || !rsp_stall;
  assign q_pop     = back_en && !q_empty;
  assign front_en  = !front_valid || !q_full || q_pop;
  assign q_push    = front_valid && front_en;
  assign req_stall = !front_en;

  pgf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .en            (front_en),
    .in_valid      (req_valid),
    .first_x       (first_x),
    .first_y       (first_y),
    .first_z       (first_z),
    .second_x      (second_x),
    .second_y      (second_y),
    .second_z      (second_z),
    .first_mass    (first_mass),
    .second_mass   (second_mass),
    .gravity_scale (gravity_scale),
    .out_valid     (front_valid),
    .out_pair      (front_pair)
  );

  pgf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .pop     (q_pop),
    .wr_data (front_pair),
    .rd_data (head_pair),
    .full    (q_full),
    .empty   (q_empty)
  );

  pgf_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (back_en),
    .in_valid  (!q_empty),
    .in_pair   (head_pair),
    .out_valid (root_valid),
    .out_pair  (root_pair),
    .out_root  (root)
  );

  pgf_div u_div (
    .clk           (clk),
    .rst           (rst),
    .en            (back_en),
    .in_valid      (root_valid),
    .in_pair       (root_pair),
    .in_root       (root),
    .out_valid     (rsp_valid),
    .force_x       (force_x),
    .force_y       (force_y),
    .force_z       (force_z),
    .zero_distance (zero_distance),
    .saturated     (saturated)
  );

endmodule

FILE: src/pgf_front.sv
// ----------------------------------------------------------------------------
// pgf_front
// Differences, squared distance and mass products; six register stages.
// ----------------------------------------------------------------------------
module pgf_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [pgf_pkg::CoordW-1:0]   first_x,
  input  logic signed [pgf_pkg::CoordW-1:0]   first_y,
  input  logic signed [pgf_pkg::CoordW-1:0]   first_z,
  input  logic signed [pgf_pkg::CoordW-1:0]   second_x,
  input  logic signed [pgf_pkg::CoordW-1:0]   second_y,
  input  logic signed [pgf_pkg::CoordW-1:0]   second_z,
  input  logic [pgf_pkg::MassW-1:0]           first_mass,
  input  logic [pgf_pkg::MassW-1:0]           second_mass,
  input  logic [pgf_pkg::ScaleW-1:0]          gravity_scale,
  output logic                                out_valid,
  output pgf_pkg::pair_t                      out_pair
);

  localparam int Stages = 6;

  logic [Stages-1:0] vld;

  logic signed [pgf_pkg::CoordW-1:0] pa [pgf_pkg::Axes];
  logic signed [pgf_pkg::CoordW-1:0] pb [pgf_pkg::Axes];
  logic signed [pgf_pkg::MagW-1:0]   diff [pgf_pkg::Axes];
  logic [pgf_pkg::MagW-1:0]          mag_c [pgf_pkg::Axes];
  logic [pgf_pkg::Axes-1:0]          pos_c;

  logic [pgf_pkg::MagW-1:0]   f1_mag [pgf_pkg::Axes];
  logic [pgf_pkg::Axes-1:0]   f1_pos;
  logic [pgf_pkg::MassW-1:0]  f1_m1, f1_m2;

  logic [pgf_pkg::SqW-1:0]    f2_sq [pgf_pkg::Axes];
  logic [pgf_pkg::GmW-1:0]    f2_gm;
  logic [pgf_pkg::MassW-1:0]  f2_m2;
  logic [pgf_pkg::MagW-1:0]   f2_mag [pgf_pkg::Axes];
  logic [pgf_pkg::Axes-1:0]   f2_pos;

  logic [pgf_pkg::SumW-1:0]   f3_sum;
  logic [pgf_pkg::GmW-1:0]    f3_pp_lo, f3_pp_hi;
  logic [pgf_pkg::MagW-1:0]   f3_mag [pgf_pkg::Axes];
  logic [pgf_pkg::Axes-1:0]   f3_pos;

  logic [pgf_pkg::ProdW-1:0]  f4_prod;
  logic [pgf_pkg::SumW-1:0]   f4_sum;
  logic                       f4_zero;
  logic [pgf_pkg::MagW-1:0]   f4_mag [pgf_pkg::Axes];
  logic [pgf_pkg::Axes-1:0]   f4_pos;

  logic [pgf_pkg::PrW-1:0]    f5_pr [pgf_pkg::Axes][pgf_pkg::Chunks];
  logic [pgf_pkg::SumW-1:0]   f5_sum;
  logic                       f5_zero;
  logic [pgf_pkg::Axes-1:0]   f5_pos;

  logic [pgf_pkg::PmW-1:0]    pm_c [pgf_pkg::Axes];

  assign pa[0] = first_x;
  assign pa[1] = first_y;
  assign pa[2] = first_z;
  assign pb[0] = second_x;
  assign pb[1] = second_y;
  assign pb[2] = second_z;

  always_comb begin
    for (int i = 0; i < pgf_pkg::Axes; i++) begin
      diff[i]  = pgf_pkg::MagW'(pa[i]) - pgf_pkg::MagW'(pb[i]);
      mag_c[i] = diff[i][pgf_pkg::MagW-1] ? pgf_pkg::MagW'(-diff[i])
                                          : pgf_pkg::MagW'(diff[i]);
      pos_c[i] = !diff[i][pgf_pkg::MagW-1] && (diff[i] != '0);
    end
  end

  // sum of the three shifted partial products per axis
  always_comb begin
    for (int i = 0; i < pgf_pkg::Axes; i++) begin
      pm_c[i] = '0;
      for (int c = 0; c < pgf_pkg::Chunks; c++) begin
        pm_c[i] = pm_c[i] + (pgf_pkg::PmW'(f5_pr[i][c]) << (c * pgf_pkg::ChunkW));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Stages-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: differences
      for (int i = 0; i < pgf_pkg::Axes; i++) begin
        f1_mag[i] <= mag_c[i];
      end
      f1_pos <= pos_c;
      f1_m1  <= first_mass;
      f1_m2  <= second_mass;

      // stage 2: squares and G*m1
      for (int i = 0; i < pgf_pkg::Axes; i++) begin
        f2_sq[i]  <= pgf_pkg::SqW'(f1_mag[i]) * pgf_pkg::SqW'(f1_mag[i]);
        f2_mag[i] <= f1_mag[i];
      end
      f2_gm  <= pgf_pkg::GmW'(gravity_scale) * pgf_pkg::GmW'(f1_m1);
      f2_m2  <= f1_m2;
      f2_pos <= f1_pos;

      // stage 3: distance sum and halves of the mass product
      f3_sum   <= f2_sq[0] + f2_sq[1] + f2_sq[2];
      f3_pp_lo <= pgf_pkg::GmW'(f2_gm[pgf_pkg::ChunkW-1:0]) * pgf_pkg::GmW'(f2_m2);
      f3_pp_hi <= pgf_pkg::GmW'(f2_gm[pgf_pkg::GmW-1:pgf_pkg::ChunkW])
                  * pgf_pkg::GmW'(f2_m2);
      for (int i = 0; i < pgf_pkg::Axes; i++) begin
        f3_mag[i] <= f2_mag[i];
      end
      f3_pos <= f2_pos;

      // stage 4: full mass product
      f4_prod <= pgf_pkg::ProdW'(f3_pp_lo)
                 + (pgf_pkg::ProdW'(f3_pp_hi) << pgf_pkg::ChunkW);
      f4_sum  <= f3_sum;
      f4_zero <= (f3_sum == '0);
      for (int i = 0; i < pgf_pkg::Axes; i++) begin
        f4_mag[i] <= f3_mag[i];
      end
      f4_pos <= f3_pos;

      // stage 5: product times |d| in 32-bit chunks
      for (int i = 0; i < pgf_pkg::Axes; i++) begin
        for (int c = 0; c < pgf_pkg::Chunks; c++) begin
          f5_pr[i][c] <= pgf_pkg::PrW'(f4_prod[c*pgf_pkg::ChunkW +: pgf_pkg::ChunkW])
                         * pgf_pkg::PrW'(f4_mag[i]);
        end
      end
      f5_sum  <= f4_sum;
      f5_zero <= f4_zero;
      f5_pos  <= f4_pos;

      // stage 6: assemble queue word
      for (int i = 0; i < pgf_pkg::Axes; i++) begin
        out_pair.pm[i] <= pm_c[i];
      end
      out_pair.sum  <= f5_sum;
      out_pair.zero <= f5_zero;
      out_pair.pos  <= f5_pos;
    end
  end

  assign out_valid = vld[Stages-1];

endmodule

FILE: src/pgf_queue.sv
// ----------------------------------------------------------------------------
// pgf_queue
// Two-word queue between the front and back pipelines.
// ----------------------------------------------------------------------------
module pgf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic            pop,
  input  pgf_pkg::pair_t  wr_data,
  output pgf_pkg::pair_t  rd_data,
  output logic            full,
  output logic            empty
);

  pgf_pkg::pair_t slot [pgf_pkg::QDepth];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full    = (count == 2'(pgf_pkg::QDepth));
  assign empty   = (count == 2'd0);
  assign rd_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/pgf_sqrt.sv
// ----------------------------------------------------------------------------
// pgf_sqrt
// Pipelined digit-by-digit square root of the scaled squared distance.
// ----------------------------------------------------------------------------
module pgf_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  pgf_pkg::pair_t               in_pair,
  output logic                         out_valid,
  output pgf_pkg::pair_t               out_pair,
  output logic [pgf_pkg::RootW-1:0]    out_root
);

  logic [pgf_pkg::RadW-1:0] op_r  [pgf_pkg::SqrtSteps];
  logic [pgf_pkg::RadW-1:0] res_r [pgf_pkg::SqrtSteps];
  pgf_pkg::pair_t           pl_r  [pgf_pkg::SqrtSteps];
  logic [pgf_pkg::SqrtSteps-1:0] vld_r;

  for (genvar j = 0; j < pgf_pkg::SqrtSteps; j++) begin : g_step
    localparam logic [pgf_pkg::RadW-1:0] One =
      pgf_pkg::RadW'(1) << (2 * (pgf_pkg::SqrtSteps - 1 - j));

    logic [pgf_pkg::RadW-1:0] op_in;
    logic [pgf_pkg::RadW-1:0] res_in;
    logic [pgf_pkg::RadW-1:0] trial;
    logic                     vld_in;
    pgf_pkg::pair_t           pl_in;
    logic                     take;

    if (j == 0) begin : g_first
      assign op_in  = pgf_pkg::RadW'(in_pair.sum) << pgf_pkg::RadShift;
      assign res_in = '0;
      assign vld_in = in_valid;
      assign pl_in  = in_pair;
    end else begin : g_next
      assign op_in  = op_r[j-1];
      assign res_in = res_r[j-1];
      assign vld_in = vld_r[j-1];
      assign pl_in  = pl_r[j-1];
    end

    assign trial = res_in + One;
    assign take  = (op_in >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        op_r[j]  <= take ? op_in - trial : op_in;
        res_r[j] <= take ? (res_in >> 1) + One : res_in >> 1;
        pl_r[j]  <= pl_in;
      end
    end
  end

  assign out_valid = vld_r[pgf_pkg::SqrtSteps-1];
  assign out_pair  = pl_r[pgf_pkg::SqrtSteps-1];
  assign out_root  = pgf_pkg::RootW'(res_r[pgf_pkg::SqrtSteps-1]);

endmodule

FILE: src/pgf_div.sv
// ----------------------------------------------------------------------------
// pgf_div
// Denominator product, pipelined long division per axis, clamp, output word.
// ----------------------------------------------------------------------------
module pgf_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  pgf_pkg::pair_t                      in_pair,
  input  logic [pgf_pkg::RootW-1:0]           in_root,
  output logic                                out_valid,
  output logic signed [pgf_pkg::ForceW-1:0]   force_x,
  output logic signed [pgf_pkg::ForceW-1:0]   force_y,
  output logic signed [pgf_pkg::ForceW-1:0]   force_z,
  output logic                                zero_distance,
  output logic                                saturated
);

  // denominator stages
  logic                     d0_vld, d1_vld, d2_vld;
  logic [pgf_pkg::PpW-1:0]  d0_p00, d0_p01, d0_p10, d0_p11;
  pgf_pkg::pair_t           d0_pl, d1_pl;
  logic [pgf_pkg::DenW-1:0] d1_den;

  // division setup stage
  logic [pgf_pkg::Axes-1:0][pgf_pkg::DenW-1:0] d2_rem;
  logic [pgf_pkg::Axes-1:0][pgf_pkg::LowW-1:0] d2_low;
  logic [pgf_pkg::Axes-1:0]                    d2_over;
  logic [pgf_pkg::DenW-1:0]                    d2_den;
  logic [pgf_pkg::Axes-1:0]                    d2_pos;
  logic                                        d2_zero;

  // division steps
  logic [pgf_pkg::Axes-1:0][pgf_pkg::DenW-1:0] rem_r  [pgf_pkg::DivSteps];
  logic [pgf_pkg::Axes-1:0][pgf_pkg::QuoW-1:0] q_r    [pgf_pkg::DivSteps];
  logic [pgf_pkg::Axes-1:0][pgf_pkg::LowW-1:0] low_r  [pgf_pkg::DivSteps];
  logic [pgf_pkg::Axes-1:0]                    over_r [pgf_pkg::DivSteps];
  logic [pgf_pkg::Axes-1:0]                    pos_r  [pgf_pkg::DivSteps];
  logic [pgf_pkg::DenW-1:0]                    den_r  [pgf_pkg::DivSteps];
  logic [pgf_pkg::DivSteps-1:0]                zero_r;
  logic [pgf_pkg::DivSteps-1:0]                vld_r;

  logic signed [pgf_pkg::ForceW-1:0] f_c [pgf_pkg::Axes];
  logic [pgf_pkg::Axes-1:0]          s_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      d0_vld <= 1'b0;
      d1_vld <= 1'b0;
      d2_vld <= 1'b0;
    end else if (en) begin
      d0_vld <= in_valid;
      d1_vld <= d0_vld;
      d2_vld <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // partial products of sum * root
      d0_p00 <= pgf_pkg::PpW'(in_pair.sum[pgf_pkg::SumLoW-1:0])
                * pgf_pkg::PpW'(in_root[pgf_pkg::RootLoW-1:0]);
      d0_p01 <= pgf_pkg::PpW'(in_pair.sum[pgf_pkg::SumLoW-1:0])
                * pgf_pkg::PpW'(in_root[pgf_pkg::RootW-1:pgf_pkg::RootLoW]);
      d0_p10 <= pgf_pkg::PpW'(in_pair.sum[pgf_pkg::SumW-1:pgf_pkg::SumLoW])
                * pgf_pkg::PpW'(in_root[pgf_pkg::RootLoW-1:0]);
      d0_p11 <= pgf_pkg::PpW'(in_pair.sum[pgf_pkg::SumW-1:pgf_pkg::SumLoW])
                * pgf_pkg::PpW'(in_root[pgf_pkg::RootW-1:pgf_pkg::RootLoW]);
      d0_pl  <= in_pair;

      d1_den <= pgf_pkg::DenW'(d0_p00)
                + (pgf_pkg::DenW'(d0_p01) << pgf_pkg::RootLoW)
                + (pgf_pkg::DenW'(d0_p10) << pgf_pkg::SumLoW)
                + (pgf_pkg::DenW'(d0_p11) << (pgf_pkg::SumLoW + pgf_pkg::RootLoW));
      d1_pl  <= d0_pl;

      // top of the dividend must sit below the divisor, else the quotient overflows
      for (int i = 0; i < pgf_pkg::Axes; i++) begin
        d2_rem[i]  <= pgf_pkg::DenW'(d1_pl.pm[i][pgf_pkg::PmW-1:pgf_pkg::LowW]);
        d2_over[i] <= pgf_pkg::DenW'(d1_pl.pm[i][pgf_pkg::PmW-1:pgf_pkg::LowW]) >= d1_den;
        d2_low[i]  <= d1_pl.pm[i][pgf_pkg::LowW-1:0];
      end
      d2_den  <= d1_den;
      d2_pos  <= d1_pl.pos;
      d2_zero <= d1_pl.zero;
    end
  end

  for (genvar k = 0; k < pgf_pkg::DivSteps; k++) begin : g_step
    localparam int Bit = pgf_pkg::DivSteps - 1 - k;

    logic [pgf_pkg::Axes-1:0][pgf_pkg::DenW-1:0] rem_in;
    logic [pgf_pkg::Axes-1:0][pgf_pkg::QuoW-1:0] q_in;
    logic [pgf_pkg::Axes-1:0][pgf_pkg::LowW-1:0] low_in;
    logic [pgf_pkg::Axes-1:0]                    over_in;
    logic [pgf_pkg::Axes-1:0]                    pos_in;
    logic [pgf_pkg::DenW-1:0]                    den_in;
    logic                                        zero_in;
    logic                                        vld_in;
    logic [pgf_pkg::Axes-1:0]                    nb;

    if (k == 0) begin : g_first
      assign rem_in  = d2_rem;
      assign q_in    = '0;
      assign low_in  = d2_low;
      assign over_in = d2_over;
      assign pos_in  = d2_pos;
      assign den_in  = d2_den;
      assign zero_in = d2_zero;
      assign vld_in  = d2_vld;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign q_in    = q_r[k-1];
      assign low_in  = low_r[k-1];
      assign over_in = over_r[k-1];
      assign pos_in  = pos_r[k-1];
      assign den_in  = den_r[k-1];
      assign zero_in = zero_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    // dividend bits below the top part; the lowest ones are always zero
    for (genvar i = 0; i < pgf_pkg::Axes; i++) begin : g_bit
      if (Bit >= pgf_pkg::LowW) begin : g_low
        assign nb[i] = low_in[i][Bit - pgf_pkg::LowW];
      end else begin : g_zero
        assign nb[i] = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      logic [pgf_pkg::DenW:0] t;
      logic                   ge;
      if (en) begin
        for (int i = 0; i < pgf_pkg::Axes; i++) begin
          t  = {rem_in[i], nb[i]};
          ge = (t >= {1'b0, den_in});
          rem_r[k][i] <= ge ? pgf_pkg::DenW'(t - {1'b0, den_in}) : pgf_pkg::DenW'(t);
          q_r[k][i]   <= {q_in[i][pgf_pkg::QuoW-2:0], ge};
        end
        low_r[k]  <= low_in;
        over_r[k] <= over_in;
        pos_r[k]  <= pos_in;
        den_r[k]  <= den_in;
        zero_r[k] <= zero_in;
      end
    end
  end

  // sign and clamp
  always_comb begin
    logic [pgf_pkg::QuoW-1:0] q;
    logic                     ov;
    for (int i = 0; i < pgf_pkg::Axes; i++) begin
      q  = q_r[pgf_pkg::DivSteps-1][i];
      ov = over_r[pgf_pkg::DivSteps-1][i];
      if (zero_r[pgf_pkg::DivSteps-1]) begin
        f_c[i] = '0;
        s_c[i] = 1'b0;
      end else if (pos_r[pgf_pkg::DivSteps-1][i]) begin
        if (ov || (q[pgf_pkg::QuoW-1] && (q[pgf_pkg::QuoW-2:0] != '0))) begin
          f_c[i] = pgf_pkg::ForceMin;
          s_c[i] = 1'b1;
        end else begin
          f_c[i] = $signed(pgf_pkg::ForceW'(0) - pgf_pkg::ForceW'(q));
          s_c[i] = 1'b0;
        end
      end else begin
        if (ov || q[pgf_pkg::QuoW-1]) begin
          f_c[i] = pgf_pkg::ForceMax;
          s_c[i] = 1'b1;
        end else begin
          f_c[i] = $signed(pgf_pkg::ForceW'(q));
          s_c[i] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld_r[pgf_pkg::DivSteps-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      force_x       <= f_c[0];
      force_y       <= f_c[1];
      force_z       <= f_c[2];
      zero_distance <= zero_r[pgf_pkg::DivSteps-1];
      saturated     <= |s_c;
    end
  end

endmodule

FILE: src/pgf_checker.sv
// ----------------------------------------------------------------------------
// pgf_checker
// Port-level checks on the pair force block, bound to the top level.
// ----------------------------------------------------------------------------
`include "pairwise_gravity_force_assert.svh"

module pgf_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [pgf_pkg::ScaleW-1:0]          cfg_data,
  input  logic                                req_valid,
  input  logic                                req_stall,
  input  logic signed [pgf_pkg::CoordW-1:0]   first_x,
  input  logic signed [pgf_pkg::CoordW-1:0]   first_y,
  input  logic signed [pgf_pkg::CoordW-1:0]   first_z,
  input  logic signed [pgf_pkg::CoordW-1:0]   second_x,
  input  logic signed [pgf_pkg::CoordW-1:0]   second_y,
  input  logic signed [pgf_pkg::CoordW-1:0]   second_z,
  input  logic [pgf_pkg::MassW-1:0]           first_mass,
  input  logic [pgf_pkg::MassW-1:0]           second_mass,
  input  logic                                rsp_valid,
  input  logic                                rsp_stall,
  input  logic signed [pgf_pkg::ForceW-1:0]   force_x,
  input  logic signed [pgf_pkg::ForceW-1:0]   force_y,
  input  logic signed [pgf_pkg::ForceW-1:0]   force_z,
  input  logic                                zero_distance,
  input  logic                                saturated
);

  // a held response keeps its word
  `PGF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(force_x) && $stable(force_y) && $stable(force_z) && $stable(zero_distance) && $stable(saturated))

  // coincident positions give no force and no clamp
  `PGF_ASSERT_IMPL(a_zero_force, rsp_valid && zero_distance, force_x == 0 && force_y == 0 && force_z == 0 && !saturated)

  // a clamp shows up as a component at a range limit
  `PGF_ASSERT_IMPL(a_sat_limit, rsp_valid && saturated, force_x == pgf_pkg::ForceMax || force_x == pgf_pkg::ForceMin || force_y == pgf_pkg::ForceMax || force_y == pgf_pkg::ForceMin || force_z == pgf_pkg::ForceMax || force_z == pgf_pkg::ForceMin)

  // reset drops any pending response
  `PGF_ASSERT_RESET(a_reset_empty, rst, !rsp_valid)

endmodule

bind pairwise_gravity_force pgf_checker u_checker (.*);
